@@ rtl/sbca_pkg.sv @@
// ----------------------------------------------------------------------------
// sbca_pkg: shared types and codes of the slab bitmap chunk allocator
// Result status codes, register layout, slab geometry and the result bundle.
// ----------------------------------------------------------------------------
package sbca_pkg;

	// result status codes
	localparam logic [2:0] ST_GRANTED     = 3'd0;
	localparam logic [2:0] ST_GRANTED_NEW = 3'd1;
	localparam logic [2:0] ST_OVERSIZE    = 3'd2;
	localparam logic [2:0] ST_NO_SLAB     = 3'd3;
	localparam logic [2:0] ST_FREED       = 3'd4;
	localparam logic [2:0] ST_FREE_FWD    = 3'd5;
	localparam logic [2:0] ST_IGNORED     = 3'd6;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// configuration register
	localparam int          BB_W      = 22;
	localparam logic [21:0] BB_RESET  = 22'd262144;
	localparam logic [1:0]  ADDR_BB   = 2'd0;
	localparam int          REQ_W     = 32;

	// slab geometry, fixed by the request and result port widths
	localparam int CHUNKS_IN_SLAB = 8;
	localparam int SLAB_LIMIT     = 16;
	localparam int SLAB_W         = $clog2(SLAB_LIMIT);
	localparam int CHUNK_W        = $clog2(CHUNKS_IN_SLAB);
	localparam int USED_W         = $clog2(CHUNKS_IN_SLAB + 1);
	localparam int COUNT_W        = $clog2(SLAB_LIMIT + 1);

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slab_number;
		logic [2:0] chunk_number;
		logic [4:0] open_slabs;
	} sbca_result_t;

endpackage

@@ rtl/sbca_slab_mem.sv @@
// ----------------------------------------------------------------------------
// sbca_slab_mem: per-slab bitmap and used-count storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbca_slab_mem #(
	parameter int ROWS = 16,
	parameter int AW   = 4,
	parameter int BW   = 8,
	parameter int UW   = 4
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [BW-1:0] rd_bitmap,
	output logic [UW-1:0] rd_used,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [BW-1:0] wr_bitmap,
	input  logic [UW-1:0] wr_used
);

	logic [BW-1:0] bitmap_mem [ROWS];
	logic [UW-1:0] used_mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bitmap_mem[wr_addr] <= wr_bitmap;
			used_mem[wr_addr]   <= wr_used;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_bitmap <= bitmap_mem[rd_addr];
			rd_used   <= used_mem[rd_addr];
		end
	end

endmodule

@@ rtl/sbca_seq.sv @@
// ----------------------------------------------------------------------------
// sbca_seq: request sequencer of the slab allocator
// Scans slab rows one per cycle through the slab memory and decides grants.
// ----------------------------------------------------------------------------
module sbca_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [31:0]           request_bytes,
	input  logic                  handle_null,
	input  logic [3:0]            free_slab,
	input  logic [2:0]            free_chunk,
	input  logic [21:0]           block_bytes,
	output logic                  done,
	output sbca_pkg::sbca_result_t result,
	output logic                  rd_en,
	output logic [sbca_pkg::SLAB_W-1:0]         rd_addr,
	input  logic [sbca_pkg::CHUNKS_IN_SLAB-1:0] rd_bitmap,
	input  logic [sbca_pkg::USED_W-1:0]         rd_used,
	output logic                  wr_en,
	output logic [sbca_pkg::SLAB_W-1:0]         wr_addr,
	output logic [sbca_pkg::CHUNKS_IN_SLAB-1:0] wr_bitmap,
	output logic [sbca_pkg::USED_W-1:0]         wr_used
);
	import sbca_pkg::*;

	localparam int SW  = SLAB_W;
	localparam int CW  = CHUNK_W;
	localparam int UW  = USED_W;
	localparam int CNW = COUNT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FCHK = 2'd3;

	logic [1:0]    state_q, state_d;
	logic          kind_q;
	logic [31:0]   req_q;
	logic          null_q;
	logic [3:0]    fslab_q;
	logic [2:0]    fchunk_q;
	logic [CNW-1:0] scan_q, scan_d;
	logic          pend_q, pend_d;
	logic [SW-1:0] chk_q, chk_d;
	logic [CNW-1:0] count_q, count_d;
	logic          done_q, done_d;
	sbca_result_t  res_q, res_d;

	logic          row_open;
	logic          hit;
	logic          issue;
	logic          ff_found;
	logic [CW-1:0] ff_idx;
	logic          free_ok;
	logic          bit_set;

	// lowest clear bit of the row just read
	always_comb begin
		ff_found = 1'b0;
		ff_idx   = '0;
		for (int c = 0; c < CHUNKS_IN_SLAB; c++) begin
			if (!rd_bitmap[c] && !ff_found) begin
				ff_found = 1'b1;
				ff_idx   = CW'(c);
			end
		end
	end

	assign row_open = 32'(rd_used) < CHUNKS_IN_SLAB;
	assign hit      = pend_q && row_open;
	assign issue    = scan_q < count_q;
	assign free_ok  = (32'(fslab_q) < 32'(count_q)) && (32'(fchunk_q) < CHUNKS_IN_SLAB);
	assign bit_set  = rd_bitmap[CW'(fchunk_q)];

	always_comb begin
		state_d   = state_q;
		scan_d    = scan_q;
		pend_d    = pend_q;
		chk_d     = chk_q;
		count_d   = count_q;
		done_d    = 1'b0;
		res_d     = res_q;
		rd_en     = 1'b0;
		rd_addr   = scan_q[SW-1:0];
		wr_en     = 1'b0;
		wr_addr   = chk_q;
		wr_bitmap = rd_bitmap;
		wr_used   = rd_used;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				res_d = '{status: ST_IGNORED, slab_number: 4'd0, chunk_number: 3'd0,
					open_slabs: 5'(count_q)};
				if (kind_q == KIND_ALLOC) begin
					if (req_q > {10'd0, block_bytes}) begin
						res_d.status = ST_OVERSIZE;
						done_d       = 1'b1;
						state_d      = S_IDLE;
					end else begin
						scan_d  = '0;
						pend_d  = 1'b0;
						state_d = S_SCAN;
					end
				end else if (null_q) begin
					res_d.status = ST_IGNORED;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else if (!free_ok) begin
					res_d.status = ST_FREE_FWD;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = SW'(fslab_q);
					state_d = S_FCHK;
				end
			end
			S_SCAN: begin
				priority if (hit) begin
					// grant lowest free chunk of the row checked this cycle
					wr_en     = 1'b1;
					wr_addr   = chk_q;
					wr_bitmap = rd_bitmap | (CHUNKS_IN_SLAB'(1) << ff_idx);
					wr_used   = rd_used + UW'(1);
					res_d.status       = ST_GRANTED;
					res_d.slab_number  = 4'(chk_q);
					res_d.chunk_number = 3'(ff_idx);
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (issue) begin
					rd_en  = 1'b1;
					chk_d  = scan_q[SW-1:0];
					pend_d = 1'b1;
					scan_d = scan_q + CNW'(1);
				end else if (32'(count_q) >= SLAB_LIMIT) begin
					res_d.status = ST_NO_SLAB;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					// open a new slab holding only chunk 0
					wr_en     = 1'b1;
					wr_addr   = count_q[SW-1:0];
					wr_bitmap = CHUNKS_IN_SLAB'(1);
					wr_used   = UW'(1);
					count_d   = count_q + CNW'(1);
					res_d.status       = ST_GRANTED_NEW;
					res_d.slab_number  = 4'(count_q);
					res_d.chunk_number = 3'd0;
					res_d.open_slabs   = 5'(count_q + CNW'(1));
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FCHK: begin
				wr_addr = SW'(fslab_q);
				if (bit_set) begin
					wr_en     = 1'b1;
					wr_bitmap = rd_bitmap & ~(CHUNKS_IN_SLAB'(1) << CW'(fchunk_q));
					wr_used   = (rd_used != '0) ? rd_used - UW'(1) : rd_used;
					res_d.status       = ST_FREED;
					res_d.slab_number  = fslab_q;
					res_d.chunk_number = fchunk_q;
				end else begin
					res_d.status = ST_FREE_FWD;
				end
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			pend_q  <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			pend_q  <= pend_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// request fields and result payload carry no reset
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			kind_q   <= kind;
			req_q    <= request_bytes;
			null_q   <= handle_null;
			fslab_q  <= free_slab;
			fchunk_q <= free_chunk;
		end
		chk_q <= chk_d;
		res_q <= res_d;
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule

@@ rtl/slab_bitmap_chunk_allocator.sv @@
// ----------------------------------------------------------------------------
// slab_bitmap_chunk_allocator: first-fit chunk allocator over slab bitmaps
// Grants the lowest free chunk of the lowest non-full slab, opens new slabs
// on demand, frees chunks, and forwards oversize or foreign requests.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+---------------------------------
//  request   | start in, busy out            | kind, request_bytes, handle_null,
//            |                               | free_slab, free_chunk
//  result    | done strobe, one cycle        | status, slab_number,
//            |                               | chunk_number, open_slabs
//  config    | APB psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A request is taken when start is high and busy is low. Oversize, null and
// out-of-range frees are answered from the evaluate state; a free of an open
// slab first reads its row. An allocate reads one slab row per cycle through
// the single memory read port, scanning at most SLAB_LIMIT rows.
// The result strobe lasts one cycle and cannot be stalled; busy drops in the
// same cycle, so the next request may be taken right away.
// Reset clears the open slab count; rows above that count are never read, so
// the slab memory needs no clearing pass.
// ----------------------------------------------------------------------------
module slab_bitmap_chunk_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] request_bytes,
	input  logic        handle_null,
	input  logic [3:0]  free_slab,
	input  logic [2:0]  free_chunk,
	// result channel
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  slab_number,
	output logic [2:0]  chunk_number,
	output logic [4:0]  open_slabs,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sbca_pkg::*;

	localparam int SW  = SLAB_W;
	localparam int UW  = USED_W;

	logic [BB_W-1:0]           block_bytes_q;
	sbca_result_t              result;
	logic                      rd_en;
	logic [SW-1:0]             rd_addr;
	logic [CHUNKS_IN_SLAB-1:0] rd_bitmap;
	logic [UW-1:0]             rd_used;
	logic                      wr_en;
	logic [SW-1:0]             wr_addr;
	logic [CHUNKS_IN_SLAB-1:0] wr_bitmap;
	logic [UW-1:0]             wr_used;

	// write block size only at the access phase of a write to its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BB_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_BB) begin
			block_bytes_q <= pwdata[BB_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_BB) ? {10'd0, block_bytes_q} : 32'd0;

	sbca_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.request_bytes (request_bytes),
		.handle_null   (handle_null),
		.free_slab     (free_slab),
		.free_chunk    (free_chunk),
		.block_bytes   (block_bytes_q),
		.done          (done),
		.result        (result),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_bitmap     (rd_bitmap),
		.rd_used       (rd_used),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_bitmap     (wr_bitmap),
		.wr_used       (wr_used)
	);

	sbca_slab_mem #(
		.ROWS (SLAB_LIMIT),
		.AW   (SW),
		.BW   (CHUNKS_IN_SLAB),
		.UW   (UW)
	) u_mem (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_bitmap (rd_bitmap),
		.rd_used   (rd_used),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_bitmap (wr_bitmap),
		.wr_used   (wr_used)
	);

	assign status       = result.status;
	assign slab_number  = result.slab_number;
	assign chunk_number = result.chunk_number;
	assign open_slabs   = result.open_slabs;

endmodule

@@ rtl/sbca_checker.sv @@
// ----------------------------------------------------------------------------
// sbca_checker: port-level checks of the slab allocator
// Watches request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sbca_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status,
	input logic [3:0] slab_number,
	input logic [2:0] chunk_number
);
	import sbca_pkg::*;

	// a taken request always keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// every result closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	// busy ends exactly with a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// one result per request: never two strobes in a row
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// no location reported for forwarded, exhausted or ignored requests
	a_no_location: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_OVERSIZE || status == ST_NO_SLAB ||
			status == ST_FREE_FWD || status == ST_IGNORED)
		|-> slab_number == 4'd0 && chunk_number == 3'd0)
		else $error("location reported on a result without one");

endmodule

bind slab_bitmap_chunk_allocator sbca_checker u_sbca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.slab_number  (slab_number),
	.chunk_number (chunk_number)
);
